>>> rtl/core/lhk_pkg.sv
`default_nettype none

package lhk_pkg;

  // Link timing in milliseconds
  localparam logic [31:0] HELLO_RETRY_MS  = 32'd2000;
  localparam logic [31:0] KEEPALIVE_MS    = 32'd3000;
  localparam logic [31:0] PEER_TIMEOUT_MS = 32'd8000;

  // SysEx framing
  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END   = 8'hF7;
  localparam logic [2:0] ID_LEN    = 3'd7;

  // Register map, index = paddr[4:2]
  localparam int          CFG_ADDR_W        = 5;
  localparam logic [2:0]  REG_LINK_CHANNEL  = 3'd0;
  localparam logic [2:0]  REG_HS_CONTROL    = 3'd1;
  localparam logic [2:0]  REG_HELLO_CODE    = 3'd2;
  localparam logic [2:0]  REG_ACK_CODE      = 3'd3;
  localparam logic [2:0]  REG_KEEPALIVE     = 3'd4;
  localparam logic [2:0]  REG_MAKER_ID      = 3'd5;
  localparam logic [2:0]  REG_SIGNATURE     = 3'd6;
  localparam logic [2:0]  REG_PRESENCE      = 3'd7;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CC    = 2'd2,
    ACT_SYSEX = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MSG_STATUS = 2'd0,
    MSG_CC     = 2'd1,
    MSG_SYSEX  = 2'd2
  } msg_kind_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] now_ms;
    logic [4:0]  rx_channel;
    logic [6:0]  rx_control;
    logic [6:0]  rx_value;
    logic [7:0]  rx_byte;
    logic        rx_final;
  } item_t;

  typedef struct packed {
    msg_kind_t   msg_kind;
    logic [4:0]  tx_channel;
    logic [6:0]  tx_control;
    logic [6:0]  tx_value;
    logic [7:0]  tx_byte;
    logic        last;
    logic        handled;
    logic        peer_alive;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/link_handshake_keepalive_unit.sv
`default_nettype none

// Peer-link handshake and keepalive engine.
// Requests enter on item/item_valid/item_stall: begin, tick, received control
// change or received SysEx byte. Each request yields one or more results on
// result/result_valid/result_stall, always ending with a status result that
// carries last=1, handled and peer_alive. Begin yields nine results (hello,
// seven identity SysEx bytes, status); a tick up to three; a control change
// up to two; a SysEx byte one.
// A request is registered, then evaluated as it moves into the burst
// register, which also applies the link state update. The first result
// comes out of the burst register, which follows the request register;
// results follow one per cycle while result_stall is low; a new request
// is taken every cycle as long as its predecessor's burst drains, so
// single-result requests run at one per cycle while results are not stalled.
// A stalled result holds; the request register fills and then item_stall
// rises until the burst ends. Reset (rst, synchronous) clears the link state,
// empties both stages and restores the register defaults. Write registers
// over the APB port only while no request is in flight.
module link_handshake_keepalive_unit
  import lhk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire item_t                 item,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  output result_t                    result,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // configuration registers
  logic [4:0]  link_channel;
  logic [6:0]  handshake_control;
  logic [6:0]  hello_code;
  logic [6:0]  ack_code;
  logic [6:0]  keepalive_code;
  logic [6:0]  maker_id;
  logic [23:0] identity_signature;
  logic [6:0]  presence_byte;

  // link state
  logic        started, started_next;
  logic        acknowledged, acknowledged_next;
  logic [31:0] hello_time, hello_time_next;
  logic [31:0] keepalive_time, keepalive_time_next;
  logic [31:0] peer_time, peer_time_next;
  logic [2:0]  sysex_count, sysex_count_next;
  logic        sysex_ok, sysex_ok_next;

  // request register
  item_t       pend;
  logic        pend_full;

  // burst register: the results of one request, emitted by index
  logic        burst_valid;
  logic        burst_begin;
  logic [1:0]  burst_ncc;
  logic [6:0]  burst_cc0;
  logic [6:0]  burst_cc1;
  logic        burst_handled;
  logic        burst_alive;
  logic [3:0]  burst_idx;

  // evaluation of the pending request
  logic        handled_next;
  logic        alive_next;
  logic [1:0]  ncc_next;
  logic [6:0]  cc0_next;
  logic [6:0]  cc1_next;
  logic        send_ka;
  logic        send_hello;
  logic [31:0] d_hello, d_ka, d_peer, d_alive;
  logic        cc_match;
  logic        id_ok;

  logic        cfg_wr;
  logic        out_fire;
  logic        burst_final;
  logic [3:0]  burst_last_idx;
  logic        load;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_channel       <= 5'd1;
      handshake_control  <= 7'd0;
      hello_code         <= 7'd1;
      ack_code           <= 7'd2;
      keepalive_code     <= 7'd3;
      maker_id           <= 7'd125;
      identity_signature <= 24'd0;
      presence_byte      <= 7'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LINK_CHANNEL: link_channel       <= pwdata[4:0];
        REG_HS_CONTROL:   handshake_control  <= pwdata[6:0];
        REG_HELLO_CODE:   hello_code         <= pwdata[6:0];
        REG_ACK_CODE:     ack_code           <= pwdata[6:0];
        REG_KEEPALIVE:    keepalive_code     <= pwdata[6:0];
        REG_MAKER_ID:     maker_id           <= pwdata[6:0];
        REG_SIGNATURE:    identity_signature <= pwdata[23:0];
        REG_PRESENCE:     presence_byte      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LINK_CHANNEL: prdata = {27'd0, link_channel};
      REG_HS_CONTROL:   prdata = {25'd0, handshake_control};
      REG_HELLO_CODE:   prdata = {25'd0, hello_code};
      REG_ACK_CODE:     prdata = {25'd0, ack_code};
      REG_KEEPALIVE:    prdata = {25'd0, keepalive_code};
      REG_MAKER_ID:     prdata = {25'd0, maker_id};
      REG_SIGNATURE:    prdata = {8'd0, identity_signature};
      REG_PRESENCE:     prdata = {25'd0, presence_byte};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------- handshakes
  assign out_fire       = result_valid && !result_stall;
  assign burst_last_idx = burst_begin ? 4'd8 : {2'd0, burst_ncc};
  assign burst_final    = (burst_idx == burst_last_idx);

  // Move the pending request into the burst stage once the burst is empty
  // or its final result leaves in this cycle.
  assign load       = pend_full && (!burst_valid || (out_fire && burst_final));
  assign item_stall = pend_full && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      pend_full <= 1'b1;
    end else if (load) begin
      pend_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      pend <= item;
    end
  end

  // ---------------------------------------------------------- evaluation
  assign d_hello  = pend.now_ms - hello_time;
  assign d_ka     = pend.now_ms - keepalive_time;
  assign d_peer   = pend.now_ms - peer_time;
  assign cc_match = (pend.rx_channel == link_channel) &&
                    (pend.rx_control == handshake_control);
  assign id_ok    = (sysex_count >= (ID_LEN - 3'd1)) && sysex_ok &&
                    (pend.rx_byte == SYX_END);

  always_comb begin
    started_next        = started;
    acknowledged_next   = acknowledged;
    hello_time_next     = hello_time;
    keepalive_time_next = keepalive_time;
    peer_time_next      = peer_time;
    sysex_count_next    = sysex_count;
    sysex_ok_next       = sysex_ok;
    handled_next        = 1'b0;
    send_ka             = 1'b0;
    send_hello          = 1'b0;
    cc0_next            = hello_code;
    cc1_next            = hello_code;
    ncc_next            = 2'd0;

    unique case (pend.action)
      ACT_BEGIN: begin
        started_next        = 1'b1;
        acknowledged_next   = 1'b0;
        hello_time_next     = pend.now_ms;
        keepalive_time_next = 32'd0;
        peer_time_next      = 32'd0;
        ncc_next            = 2'd1;
      end
      ACT_TICK: begin
        if (started) begin
          if (!acknowledged) begin
            send_hello = (d_hello >= HELLO_RETRY_MS);
          end else begin
            send_ka    = (d_ka >= KEEPALIVE_MS);
            send_hello = (d_peer > PEER_TIMEOUT_MS);
          end
        end
        if (send_ka) begin
          keepalive_time_next = pend.now_ms;
        end
        if (send_hello) begin
          acknowledged_next = 1'b0;
          hello_time_next   = pend.now_ms;
        end
        // keepalive goes out ahead of a re-hello
        cc0_next = send_ka ? keepalive_code : hello_code;
        ncc_next = {1'b0, send_ka} + {1'b0, send_hello};
      end
      ACT_CC: begin
        if (cc_match) begin
          handled_next = 1'b1;
          if (pend.rx_value == hello_code) begin
            peer_time_next = pend.now_ms;
            cc0_next       = ack_code;
            ncc_next       = {1'b0, started};
          end else if (pend.rx_value == ack_code) begin
            acknowledged_next = 1'b1;
            peer_time_next    = pend.now_ms;
          end else if (pend.rx_value == keepalive_code) begin
            peer_time_next = pend.now_ms;
          end
        end
      end
      ACT_SYSEX: begin
        if (!pend.rx_final) begin
          case (sysex_count)
            3'd0: if (pend.rx_byte != SYX_START) sysex_ok_next = 1'b0;
            3'd1: if (pend.rx_byte != {1'b0, maker_id}) sysex_ok_next = 1'b0;
            3'd2: if (pend.rx_byte != identity_signature[23:16]) sysex_ok_next = 1'b0;
            3'd3: if (pend.rx_byte != identity_signature[15:8]) sysex_ok_next = 1'b0;
            3'd4: if (pend.rx_byte != identity_signature[7:0]) sysex_ok_next = 1'b0;
            default: ;
          endcase
          if (sysex_count < ID_LEN) begin
            sysex_count_next = sysex_count + 3'd1;
          end
        end else begin
          if (id_ok) begin
            handled_next   = 1'b1;
            peer_time_next = pend.now_ms;
          end
          sysex_count_next = 3'd0;
          sysex_ok_next    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // peer_alive reflects the state after this request
  assign d_alive    = pend.now_ms - peer_time_next;
  assign alive_next = acknowledged_next && (d_alive <= PEER_TIMEOUT_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      acknowledged   <= 1'b0;
      hello_time     <= 32'd0;
      keepalive_time <= 32'd0;
      peer_time      <= 32'd0;
      sysex_count    <= 3'd0;
      sysex_ok       <= 1'b1;
    end else if (load) begin
      started        <= started_next;
      acknowledged   <= acknowledged_next;
      hello_time     <= hello_time_next;
      keepalive_time <= keepalive_time_next;
      peer_time      <= peer_time_next;
      sysex_count    <= sysex_count_next;
      sysex_ok       <= sysex_ok_next;
    end
  end

  // --------------------------------------------------------------- burst
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_idx   <= 4'd0;
    end else if (load) begin
      burst_valid <= 1'b1;
      burst_idx   <= 4'd0;
    end else if (out_fire) begin
      if (burst_final) begin
        burst_valid <= 1'b0;
        burst_idx   <= 4'd0;
      end else begin
        burst_idx <= burst_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_begin   <= (pend.action == ACT_BEGIN);
      burst_ncc     <= ncc_next;
      burst_cc0     <= cc0_next;
      burst_cc1     <= cc1_next;
      burst_handled <= handled_next;
      burst_alive   <= alive_next;
    end
  end

  // Pick the result at the current index. The burst registers are stable while
  // a burst is out, and the config registers too if the user keeps APB writes out of it, so a stalled result holds.
  always_comb begin
    result = '0;
    result.msg_kind = MSG_STATUS;
    if (burst_final) begin
      result.last       = 1'b1;
      result.handled    = burst_handled;
      result.peer_alive = burst_alive;
    end else if (burst_begin && (burst_idx != 4'd0)) begin
      result.msg_kind = MSG_SYSEX;
      case (burst_idx)
        4'd1:    result.tx_byte = SYX_START;
        4'd2:    result.tx_byte = {1'b0, maker_id};
        4'd3:    result.tx_byte = identity_signature[23:16];
        4'd4:    result.tx_byte = identity_signature[15:8];
        4'd5:    result.tx_byte = identity_signature[7:0];
        4'd6:    result.tx_byte = {1'b0, presence_byte};
        default: result.tx_byte = SYX_END;
      endcase
    end else begin
      result.msg_kind   = MSG_CC;
      result.tx_channel = link_channel;
      result.tx_control = handshake_control;
      result.tx_value   = (burst_idx == 4'd0) ? burst_cc0 : burst_cc1;
    end
  end

  assign result_valid = burst_valid;

  // ----------------------------------------------------------- assertions
  a_stall_needs_pend : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> pend_full)
    else $error("request stalled with empty request register");

  a_burst_continues : assert property (@(posedge clk) disable iff (rst)
    (out_fire && !burst_final) |=> (result_valid && burst_idx == $past(burst_idx) + 4'd1))
    else $error("burst dropped before its status result");

  a_status_is_last : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.msg_kind != MSG_STATUS) |-> !result.last)
    else $error("last flag on a send result");

  a_begin_state : assert property (@(posedge clk) disable iff (rst)
    (load && pend.action == ACT_BEGIN) |=> (started && !acknowledged && burst_begin))
    else $error("begin did not restart the link");

endmodule

`default_nettype wire

>>> bench/link_handshake_keepalive_checker.sv
`timescale 1ns / 100ps

module link_handshake_keepalive_checker
  import lhk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire item_t                 item,
  input  wire logic                  item_valid,
  input  wire logic                  item_stall,
  input  wire result_t               result,
  input  wire logic                  result_valid,
  input  wire logic                  result_stall,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output int                         outstanding,
  output int                         mismatches
);

  // register copy
  logic [4:0]  link_chan;
  logic [6:0]  hs_ctl, hello_val, ack_val, keep_val, maker, presence;
  logic [23:0] signature;

  // link state copy
  logic        started, acked, syx_ok;
  logic [31:0] hello_at, keep_at, peer_at;
  logic [2:0]  syx_count;

  result_t     due_msgs[$];
  result_t     want;

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, exp_v, got_v);
  endtask

  function automatic result_t cc_msg(logic [6:0] value);
    result_t r;
    r = '0;
    r.msg_kind   = MSG_CC;
    r.tx_channel = link_chan;
    r.tx_control = hs_ctl;
    r.tx_value   = value;
    return r;
  endfunction

  function automatic result_t byte_msg(logic [7:0] b);
    result_t r;
    r = '0;
    r.msg_kind = MSG_SYSEX;
    r.tx_byte  = b;
    return r;
  endfunction

  // Advance the link by one request and queue the messages it must produce.
  task automatic step_link(item_t it);
    logic [31:0] now;
    logic        hit;
    result_t     st;
    now = it.now_ms;
    hit = 1'b0;
    case (it.action)
      ACT_BEGIN: begin
        started = 1'b1;
        acked   = 1'b0;
        keep_at = '0;
        peer_at = '0;
        due_msgs.push_back(cc_msg(hello_val));
        hello_at = now;
        due_msgs.push_back(byte_msg(SYX_START));
        due_msgs.push_back(byte_msg({1'b0, maker}));
        due_msgs.push_back(byte_msg(signature[23:16]));
        due_msgs.push_back(byte_msg(signature[15:8]));
        due_msgs.push_back(byte_msg(signature[7:0]));
        due_msgs.push_back(byte_msg({1'b0, presence}));
        due_msgs.push_back(byte_msg(SYX_END));
      end
      ACT_TICK: begin
        if (started && !acked) begin
          if (now - hello_at >= HELLO_RETRY_MS) begin
            due_msgs.push_back(cc_msg(hello_val));
            hello_at = now;
          end
        end else if (started) begin
          if (now - keep_at >= KEEPALIVE_MS) begin
            due_msgs.push_back(cc_msg(keep_val));
            keep_at = now;
          end
          if (now - peer_at > PEER_TIMEOUT_MS) begin
            acked = 1'b0;
            due_msgs.push_back(cc_msg(hello_val));
            hello_at = now;
          end
        end
      end
      ACT_CC: begin
        if (it.rx_channel == link_chan && it.rx_control == hs_ctl) begin
          hit = 1'b1;
          if (it.rx_value == hello_val) begin
            peer_at = now;
            if (started) due_msgs.push_back(cc_msg(ack_val));
          end else if (it.rx_value == ack_val) begin
            acked   = 1'b1;
            peer_at = now;
          end else if (it.rx_value == keep_val) begin
            peer_at = now;
          end
        end
      end
      default: begin
        if (!it.rx_final) begin
          case (syx_count)
            3'd0: if (it.rx_byte != SYX_START) syx_ok = 1'b0;
            3'd1: if (it.rx_byte != {1'b0, maker}) syx_ok = 1'b0;
            3'd2: if (it.rx_byte != signature[23:16]) syx_ok = 1'b0;
            3'd3: if (it.rx_byte != signature[15:8]) syx_ok = 1'b0;
            3'd4: if (it.rx_byte != signature[7:0]) syx_ok = 1'b0;
            default: ;
          endcase
          if (syx_count < ID_LEN) syx_count = syx_count + 3'd1;
        end else begin
          if (syx_count >= ID_LEN - 3'd1 && syx_ok && it.rx_byte == SYX_END) begin
            hit     = 1'b1;
            peer_at = now;
          end
          syx_count = '0;
          syx_ok    = 1'b1;
        end
      end
    endcase
    st            = '0;
    st.msg_kind   = MSG_STATUS;
    st.last       = 1'b1;
    st.handled    = hit;
    st.peer_alive = acked && (now - peer_at <= PEER_TIMEOUT_MS);
    due_msgs.push_back(st);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_chan = 5'd1;
      hs_ctl    = 7'd0;
      hello_val = 7'd1;
      ack_val   = 7'd2;
      keep_val  = 7'd3;
      maker     = 7'd125;
      signature = '0;
      presence  = 7'd1;
      started   = 1'b0;
      acked     = 1'b0;
      hello_at  = '0;
      keep_at   = '0;
      peer_at   = '0;
      syx_count = '0;
      syx_ok    = 1'b1;
      due_msgs.delete();
    end else begin
      // check the outgoing side before queueing anything new
      if (result_valid && !result_stall) begin
        if (due_msgs.size() == 0) begin
          note_mismatch("unexpected result", '0, result);
        end else begin
          want = due_msgs.pop_front();
          if (result.msg_kind != want.msg_kind)
            note_mismatch("msg_kind", want.msg_kind, result.msg_kind);
          if (result.tx_channel != want.tx_channel)
            note_mismatch("tx_channel", want.tx_channel, result.tx_channel);
          if (result.tx_control != want.tx_control)
            note_mismatch("tx_control", want.tx_control, result.tx_control);
          if (result.tx_value != want.tx_value)
            note_mismatch("tx_value", want.tx_value, result.tx_value);
          if (result.tx_byte != want.tx_byte)
            note_mismatch("tx_byte", want.tx_byte, result.tx_byte);
          if (result.last != want.last)
            note_mismatch("last", want.last, result.last);
          if (result.handled != want.handled)
            note_mismatch("handled", want.handled, result.handled);
          if (result.peer_alive != want.peer_alive)
            note_mismatch("peer_alive", want.peer_alive, result.peer_alive);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LINK_CHANNEL: link_chan = pwdata[4:0];
          REG_HS_CONTROL:   hs_ctl    = pwdata[6:0];
          REG_HELLO_CODE:   hello_val = pwdata[6:0];
          REG_ACK_CODE:     ack_val   = pwdata[6:0];
          REG_KEEPALIVE:    keep_val  = pwdata[6:0];
          REG_MAKER_ID:     maker     = pwdata[6:0];
          REG_SIGNATURE:    signature = pwdata[23:0];
          default:          presence  = pwdata[6:0];
        endcase
      end
      if (item_valid && !item_stall) step_link(item);
    end
    outstanding <= due_msgs.size();
  end

endmodule

>>> bench/link_handshake_keepalive_unit_tb.sv
`timescale 1ns / 100ps

module link_handshake_keepalive_unit_tb
  import lhk_pkg::*;
();

  localparam int IDLE_PCT     = 23;
  localparam int RANDOM_COUNT = 300;

  // SysEx packet flaws
  localparam int PKT_GOOD       = 0;
  localparam int PKT_BAD_HEADER = 1;
  localparam int PKT_SHORT      = 2;
  localparam int PKT_BAD_END    = 3;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  item_t                 item         = '0;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  result_t               result;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [31:0]           pwdata       = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int                    outstanding;
  int                    mismatches;

  // Idling on both sides is gated by this flag.
  bit          idle_on       = 1'b1;
  logic [31:0] stim_ms       = '0;
  int          requests_sent = 0;

  // Register values as written, used to build well-formed peer traffic.
  logic [4:0]  cfg_chan     = 5'd1;
  logic [6:0]  cfg_ctl      = 7'd0;
  logic [6:0]  cfg_hello    = 7'd1;
  logic [6:0]  cfg_ack      = 7'd2;
  logic [6:0]  cfg_keep     = 7'd3;
  logic [6:0]  cfg_maker    = 7'd125;
  logic [23:0] cfg_sig      = '0;
  logic [6:0]  cfg_presence = 7'd1;

  always #5 clk = ~clk;

  link_handshake_keepalive_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  link_handshake_keepalive_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // Stall the result side at random; hold it open while idling is off.
  always @(posedge clk) begin
    result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Drive one APB write: setup cycle, then access cycle; the write lands on
  // the edge that sees psel and penable both high.
  task automatic write_register(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LINK_CHANNEL: cfg_chan     = data[4:0];
      REG_HS_CONTROL:   cfg_ctl      = data[6:0];
      REG_HELLO_CODE:   cfg_hello    = data[6:0];
      REG_ACK_CODE:     cfg_ack      = data[6:0];
      REG_KEEPALIVE:    cfg_keep     = data[6:0];
      REG_MAKER_ID:     cfg_maker    = data[6:0];
      REG_SIGNATURE:    cfg_sig      = data[23:0];
      default:          cfg_presence = data[6:0];
    endcase
  endtask

  // Fill every field at random, then let the caller pin down what matters.
  function automatic item_t make_item(action_t act);
    item_t it;
    it.action     = act;
    it.now_ms     = stim_ms;
    it.rx_channel = 5'($urandom);
    it.rx_control = 7'($urandom);
    it.rx_value   = 7'($urandom);
    it.rx_byte    = 8'($urandom);
    it.rx_final   = 1'($urandom);
    return it;
  endfunction

  // Present one request and hold it until the block takes it. Valid stays
  // high on return so back-to-back requests need no extra edge.
  task automatic send_request(item_t it);
    int gap;
    gap = 0;
    if (idle_on)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    requests_sent++;
  endtask

  // Drop valid, wait until every queued message has come out, then let the
  // pipeline settle.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic tick();
    send_request(make_item(ACT_TICK));
  endtask

  // Control change from the peer on the handshake channel and control.
  task automatic peer_cc(logic [6:0] value);
    item_t it;
    it            = make_item(ACT_CC);
    it.rx_channel = cfg_chan;
    it.rx_control = cfg_ctl;
    it.rx_value   = value;
    send_request(it);
  endtask

  // Identity packet from the peer, optionally damaged. Time stands still
  // for the whole packet.
  task automatic send_packet(int flaw, int extras);
    logic [7:0] pkt [0:15];
    int         len;
    int         k;
    item_t      it;
    pkt[0] = SYX_START;
    pkt[1] = {1'b0, cfg_maker};
    pkt[2] = cfg_sig[23:16];
    pkt[3] = cfg_sig[15:8];
    pkt[4] = cfg_sig[7:0];
    pkt[5] = {1'b0, cfg_presence};
    len    = 6;
    repeat (extras) begin
      pkt[len] = 8'($urandom);
      len++;
    end
    case (flaw)
      PKT_BAD_HEADER: begin
        k      = $urandom_range(0, 4);
        pkt[k] = pkt[k] ^ (8'd1 << $urandom_range(0, 7));
      end
      PKT_SHORT: len = $urandom_range(0, 5);
      default: ;
    endcase
    pkt[len] = (flaw == PKT_BAD_END) ? 8'($urandom_range(0, 255)) : SYX_END;
    len++;
    for (k = 0; k < len; k++) begin
      it          = make_item(ACT_SYSEX);
      it.rx_byte  = pkt[k];
      it.rx_final = (k == len - 1);
      send_request(it);
    end
  endtask

  // Mostly short hops, some around the retry and keepalive periods, some
  // around the peer timeout, and now and then a jump anywhere.
  function automatic logic [31:0] time_step();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(0, 1500);
    if (pick < 80) return $urandom_range(1500, 4000);
    if (pick < 95) return $urandom_range(7000, 9000);
    return $urandom;
  endfunction

  initial begin
    item_t       it;
    int unsigned pick;
    int          base;
    int          next_cfg;
    logic [2:0]  idx;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset register values.
    stim_ms = 32'd100;  tick();              // not started: nothing sent
    stim_ms = 32'd200;  peer_cc(cfg_hello);  // handled, but no ack yet
    stim_ms = 32'd1000;
    send_request(make_item(ACT_BEGIN));
    stim_ms = 32'd2999; tick();              // just short of the retry
    stim_ms = 32'd3000; tick();              // hello retry
    stim_ms = 32'd3100; peer_cc(cfg_ack);
    stim_ms = 32'd6000; tick();              // keepalive due
    stim_ms = 32'd6500; peer_cc(cfg_keep);
    peer_cc(7'd100);                         // unknown code on the link
    it            = make_item(ACT_CC);
    it.rx_channel = cfg_chan + 5'd1;
    it.rx_control = cfg_ctl;
    it.rx_value   = cfg_hello;
    send_request(it);                        // wrong channel
    stim_ms = 32'd7000;
    send_packet(PKT_GOOD, 0);                // minimum-length identity
    stim_ms = 32'd15000; tick();             // silence at the timeout: alive
    stim_ms = 32'd15001; tick();             // one past: drop and re-hello
    send_packet(PKT_SHORT, 0);
    stim_ms = 32'hFFFF_FFFF; tick();
    stim_ms = 32'd0; tick();                 // time wraps

    // Upper extremes (maker ID at its lowest), all codes equal: hello wins.
    drain();
    write_register(REG_LINK_CHANNEL, 32'd16);
    write_register(REG_HS_CONTROL,   32'd127);
    write_register(REG_HELLO_CODE,   32'd127);
    write_register(REG_ACK_CODE,     32'd127);
    write_register(REG_KEEPALIVE,    32'd127);
    write_register(REG_MAKER_ID,     32'd0);
    write_register(REG_SIGNATURE,    32'h00FF_FFFF);
    write_register(REG_PRESENCE,     32'd127);
    stim_ms = 32'h8000_0000;
    send_request(make_item(ACT_BEGIN));
    peer_cc(7'd127);
    send_packet(PKT_GOOD, 4);                // byte count saturates
    send_packet(PKT_BAD_HEADER, 0);
    send_packet(PKT_BAD_END, 1);

    // Move hello away: ack now wins over keepalive.
    drain();
    write_register(REG_HELLO_CODE, 32'd5);
    peer_cc(7'd127);
    stim_ms = stim_ms + 32'd3000; tick();

    // Lower extremes (maker ID at its highest), with noise in the unused upper bits.
    drain();
    write_register(REG_LINK_CHANNEL, 32'hFFFF_FFE1);
    write_register(REG_HS_CONTROL,   32'hFFFF_FF80);
    write_register(REG_HELLO_CODE,   32'd0);
    write_register(REG_ACK_CODE,     32'd1);
    write_register(REG_KEEPALIVE,    32'd2);
    write_register(REG_MAKER_ID,     32'd127);
    write_register(REG_SIGNATURE,    32'hFF00_0000);
    write_register(REG_PRESENCE,     32'd0);

    // Random part: mostly link traffic that follows the protocol, with
    // stray control changes and broken packets mixed in.
    base     = requests_sent;
    next_cfg = 120;
    while (requests_sent - base < RANDOM_COUNT) begin
      idle_on = !(requests_sent - base >= 60 && requests_sent - base < 140);
      if (requests_sent - base >= next_cfg) begin
        // hold off until the link has gone quiet, then retune it
        drain();
        for (int r = 0; r < 8; r++) begin
          idx = 3'(r);
          write_register(idx, $urandom);
        end
        next_cfg += 120;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        stim_ms = stim_ms + time_step();
        send_request(make_item(ACT_BEGIN));
      end else if (pick < 36) begin
        stim_ms = stim_ms + time_step();
        tick();
      end else if (pick < 58) begin
        stim_ms = stim_ms + $urandom_range(0, 500);
        case ($urandom_range(3))
          0:       peer_cc(cfg_hello);
          1:       peer_cc(cfg_keep);
          default: peer_cc(cfg_ack);
        endcase
      end else if (pick < 68) begin
        it = make_item(ACT_CC);
        if ($urandom_range(1)) begin
          it.rx_channel = cfg_chan;
          it.rx_control = cfg_ctl;
        end
        send_request(it);
      end else if (pick < 82) begin
        send_packet(PKT_GOOD, $urandom_range(0, 3));
      end else if (pick < 90) begin
        send_packet($urandom_range(PKT_BAD_HEADER, PKT_BAD_END), $urandom_range(0, 3));
      end else if (pick < 95) begin
        send_request(make_item(ACT_SYSEX));
      end else begin
        stim_ms = $urandom;
        tick();
      end
    end
    idle_on = 1'b1;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Bail out if the link hangs.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lhk_pkg.sv
rtl/core/link_handshake_keepalive_unit.sv
bench/link_handshake_keepalive_checker.sv
bench/link_handshake_keepalive_unit_tb.sv
